/* design/ptpts_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptpts_pkg
// Shared types and constants for the PTP timestamp arithmetic pipeline.
// ----------------------------------------------------------------------------
package ptpts_pkg;

    localparam int SEC_W      = 64;
    localparam int WORD_W     = 32;
    localparam int NSEC_IN_W  = 31;
    localparam int NSEC_W     = 32;
    localparam int MODE_W     = 2;
    localparam int IN_DATA_W  = 192;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 96;

    localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SUB = 2'd1;

    localparam logic signed [NSEC_W-1:0] NSEC_PER_SEC = 32'sd1000000000;
    localparam logic signed [NSEC_W-1:0] NSEC_ZERO    = 32'sd0;

    typedef struct packed {
        logic [SEC_W-1:0]         sec;
        logic signed [NSEC_W-1:0] nsec;
        logic                     skip;
    } stage_t;

endpackage
`default_nettype wire

/* design/ptpts_arith.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptpts_arith
// First stage: 64-bit seconds add, subtract or magnitude, nanosecond add,
// subtract or magnitude.
// ----------------------------------------------------------------------------
module ptpts_arith (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [ptpts_pkg::MODE_W-1:0]          mode,
    input  wire logic [ptpts_pkg::SEC_W-1:0]           a_sec,
    input  wire logic signed [ptpts_pkg::NSEC_IN_W-1:0] a_nsec,
    input  wire logic [ptpts_pkg::SEC_W-1:0]           b_sec,
    input  wire logic signed [ptpts_pkg::NSEC_IN_W-1:0] b_nsec,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output ptpts_pkg::stage_t                          out_data
);

    logic                                  valid_reg;
    logic                                  valid_next;
    ptpts_pkg::stage_t                     data_reg;
    ptpts_pkg::stage_t                     data_next;
    logic signed [ptpts_pkg::NSEC_W-1:0]   a_n;
    logic signed [ptpts_pkg::NSEC_W-1:0]   b_n;

    assign a_n = {a_nsec[ptpts_pkg::NSEC_IN_W-1], a_nsec};
    assign b_n = {b_nsec[ptpts_pkg::NSEC_IN_W-1], b_nsec};

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_comb
    begin
        case (mode)
            ptpts_pkg::MODE_ADD:
            begin
                data_next.sec  = a_sec + b_sec;
                data_next.nsec = a_n + b_n;
                data_next.skip = 1'b0;
            end
            ptpts_pkg::MODE_SUB:
            begin
                data_next.sec  = a_sec - b_sec;
                data_next.nsec = a_n - b_n;
                data_next.skip = 1'b0;
            end
            default:
            begin
                data_next.sec  = a_sec[ptpts_pkg::SEC_W-1] ? (~a_sec + 64'd1) : a_sec;
                data_next.nsec = a_n[ptpts_pkg::NSEC_W-1] ? -a_n : a_n;
                data_next.skip = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

/* design/ptpts_fold.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptpts_fold
// Second stage: fold one second of nanosecond overflow into the seconds; magnitude words pass through.
// ----------------------------------------------------------------------------
module ptpts_fold (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ptpts_pkg::stage_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output ptpts_pkg::stage_t      out_data
);

    logic              valid_reg;
    logic              valid_next;
    ptpts_pkg::stage_t data_reg;
    ptpts_pkg::stage_t data_next;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_comb
    begin
        data_next = in_data;
        if (!in_data.skip)
        begin
            if (in_data.nsec >= ptpts_pkg::NSEC_PER_SEC)
            begin
                data_next.sec  = in_data.sec + 64'd1;
                data_next.nsec = in_data.nsec - ptpts_pkg::NSEC_PER_SEC;
            end
            else if (in_data.nsec <= -ptpts_pkg::NSEC_PER_SEC)
            begin
                data_next.sec  = in_data.sec - 64'd1;
                data_next.nsec = in_data.nsec + ptpts_pkg::NSEC_PER_SEC;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

/* design/ptpts_norm.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptpts_norm
// Third stage: give the nanoseconds the sign of the seconds; this register
// is the output word register.
// ----------------------------------------------------------------------------
module ptpts_norm (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ptpts_pkg::stage_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output ptpts_pkg::stage_t      out_data
);

    logic              valid_reg;
    logic              valid_next;
    ptpts_pkg::stage_t data_reg;
    ptpts_pkg::stage_t data_next;
    logic              sec_neg;
    logic              sec_zero;

    assign sec_neg  = in_data.sec[ptpts_pkg::SEC_W-1];
    assign sec_zero = (in_data.sec == '0);

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_comb
    begin
        data_next = in_data;
        if (!in_data.skip)
        begin
            if (sec_neg && (in_data.nsec > ptpts_pkg::NSEC_ZERO))
            begin
                data_next.sec  = in_data.sec + 64'd1;
                data_next.nsec = in_data.nsec - ptpts_pkg::NSEC_PER_SEC;
            end
            else if (!sec_neg && !sec_zero && (in_data.nsec < ptpts_pkg::NSEC_ZERO))
            begin
                data_next.sec  = in_data.sec - 64'd1;
                data_next.nsec = in_data.nsec + ptpts_pkg::NSEC_PER_SEC;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

/* design/ptp_timestamp_alu.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptp_timestamp_alu
// Add, subtract and absolute value of PTP timestamps (64-bit seconds plus
// signed nanoseconds) in a three-stage pipeline.
// ----------------------------------------------------------------------------
// One word enters per cycle while s_axis_tready is high and results leave in
// input order. The three register stages (arithmetic, nanosecond fold, sign
// normalize) each hold one word with its own valid bit; a stage takes a new
// word whenever it is empty or its word moves on, so s_axis_tready follows
// m_axis_tready through that chain and empty stages keep filling while a
// finished result waits on the output.
// ----------------------------------------------------------------------------
module ptp_timestamp_alu (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // first_sec_high, first_sec_low, first_nsec, second_sec_high,
    // second_sec_low, second_nsec, zero pad
    input  wire logic [ptpts_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // mode
    input  wire logic [ptpts_pkg::IN_USER_W-1:0]      s_axis_tuser,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // result_sec_high, result_sec_low, result_nsec, zero pad
    output logic [ptpts_pkg::OUT_DATA_W-1:0]          m_axis_tdata
);

    logic [ptpts_pkg::SEC_W-1:0]            a_sec;
    logic signed [ptpts_pkg::NSEC_IN_W-1:0] a_nsec;
    logic [ptpts_pkg::SEC_W-1:0]            b_sec;
    logic signed [ptpts_pkg::NSEC_IN_W-1:0] b_nsec;

    logic              arith_valid;
    logic              fold_ready;
    ptpts_pkg::stage_t arith_data;
    logic              fold_valid;
    logic              norm_ready;
    ptpts_pkg::stage_t fold_data;
    ptpts_pkg::stage_t norm_data;

    assign a_sec  = {s_axis_tdata[31:0], s_axis_tdata[63:32]};
    assign a_nsec = s_axis_tdata[94:64];
    assign b_sec  = {s_axis_tdata[126:95], s_axis_tdata[158:127]};
    assign b_nsec = s_axis_tdata[189:159];

    ptpts_arith u_arith (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .mode      (s_axis_tuser),
        .a_sec     (a_sec),
        .a_nsec    (a_nsec),
        .b_sec     (b_sec),
        .b_nsec    (b_nsec),
        .out_valid (arith_valid),
        .out_ready (fold_ready),
        .out_data  (arith_data)
    );

    ptpts_fold u_fold (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (arith_valid),
        .in_ready  (fold_ready),
        .in_data   (arith_data),
        .out_valid (fold_valid),
        .out_ready (norm_ready),
        .out_data  (fold_data)
    );

    ptpts_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fold_valid),
        .in_ready  (norm_ready),
        .in_data   (fold_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (norm_data)
    );

    assign m_axis_tdata = {1'b0,
                           norm_data.nsec[ptpts_pkg::NSEC_IN_W-1:0],
                           norm_data.sec[ptpts_pkg::WORD_W-1:0],
                           norm_data.sec[ptpts_pkg::SEC_W-1:ptpts_pkg::WORD_W]};

endmodule
`default_nettype wire

/* design/ptpts_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptpts_checker
// Port-level checks of the timestamp pipeline: output hold, flow and latency.
// ----------------------------------------------------------------------------
module ptpts_checker (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_axis_tvalid,
    input  wire logic                                 s_axis_tready,
    input  wire logic                                 m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    input  wire logic [ptpts_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
        else $error("input stalled with output free");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 3))
        else $error("output word without input three cycles earlier");

endmodule

bind ptp_timestamp_alu ptpts_checker u_ptpts_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
